FILE: design/pmm_pkg.sv
// Shared types and constants for the paged memory map with its fixed I/O page.
`default_nettype none
package pmm_pkg;

  localparam int unsigned PHYS_FRAMES = 1024;
  localparam int unsigned FRAME_W = $clog2(PHYS_FRAMES);
  localparam int unsigned CPU_PAGES = 256;
  localparam int unsigned PAGE_W = $clog2(CPU_PAGES);
  localparam int unsigned CNT_W = PAGE_W + 1;
  localparam logic [PAGE_W-1:0] IO_PAGE = 8'hFF;

  // Function codes of an input request.
  localparam logic [2:0] FN_RD_BYTE = 3'd0;
  localparam logic [2:0] FN_RD_WORD = 3'd1;
  localparam logic [2:0] FN_WR_BYTE = 3'd2;
  localparam logic [2:0] FN_WR_WORD = 3'd3;
  localparam logic [2:0] FN_MAP     = 3'd4;
  localparam logic [2:0] FN_UNMAP   = 3'd5;

  // Result target codes.
  localparam logic [1:0] TGT_MEM  = 2'd0;
  localparam logic [1:0] TGT_IO   = 2'd1;
  localparam logic [1:0] TGT_NONE = 2'd2;
  localparam logic [1:0] TGT_MAP  = 2'd3;

  typedef enum logic [2:0] {
    K_MEM,
    K_IO,
    K_MAP,
    K_UNMAP,
    K_NONE
  } pmm_kind_t;

  typedef enum logic [1:0] {
    BK_RUN,
    BK_MAP,
    BK_UNMAP
  } pmm_bk_state_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] address;
    logic [15:0] write_data;
    logic [9:0]  frame_base;
    logic [7:0]  owner;
    logic [7:0]  page_flags;
    logic [8:0]  page_count;
  } pmm_item_t;

  typedef struct packed {
    logic [1:0]  target;
    logic [17:0] phys_addr;
    logic        write_enable;
    logic        word_access;
    logic [7:0]  io_port;
    logic        io_replicate;
    logic [15:0] store_data;
    logic [8:0]  pages_changed;
  } pmm_result_t;

  // Classified request as it waits in the queue.
  typedef struct packed {
    pmm_kind_t          kind;
    logic               is_word;
    logic               is_write;
    logic [15:0]        addr;
    logic [15:0]        wdata;
    logic [FRAME_W-1:0] frame;
    logic [7:0]         owner;
    logic [7:0]         flags;
    logic [CNT_W-1:0]   pages;
  } pmm_req_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [7:0]         owner;
    logic [7:0]         flags;
  } pmm_entry_t;

endpackage
`default_nettype wire

FILE: design/paged_memory_map_with_io_page_core.sv
// Top level of the paged memory map with a fixed I/O page.
`default_nettype none
// A request is taken whenever start is high and busy is low; busy rises only
// when the two-entry request queue is full. Byte and word accesses flow through
// one per cycle while no map or unmap run holds the back end. Once a request
// reaches the back end, its page table entry is read from the 256-entry page
// table memory, a registered read, and its result is registered after that.
// A map request of n pages (after clipping at page 255) takes the request,
// writes the table once per page and then reports. An unmap reads and compares
// the owner once per page. Every request yields exactly one result,
// shown for one cycle with done high; the receiver cannot stall it. The page
// table is usable right after reset: per-page valid bits clear at once, so no
// clearing pass runs. The writable mask is written through cfg_valid, which is
// always ready, and should only change while no request is in flight.
module paged_memory_map_with_io_page_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire pmm_pkg::pmm_item_t item,
  output logic                    done,
  output pmm_pkg::pmm_result_t    result,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [7:0]         cfg_data
);
  import pmm_pkg::*;

  logic     q_valid;
  logic     pop;
  pmm_req_t q_req;

  assign cfg_ready = 1'b1;

  pmm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .item    (item),
    .busy    (busy),
    .pop     (pop),
    .q_valid (q_valid),
    .q_req   (q_req)
  );

  pmm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_req     (q_req),
    .pop       (pop),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .done      (done),
    .result    (result)
  );

endmodule
`default_nettype wire

FILE: design/pmm_front.sv
// Front end: classifies incoming requests and holds them in a two-entry queue.
`default_nettype none
module pmm_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire pmm_pkg::pmm_item_t item,
  output logic                    busy,
  input  wire logic               pop,
  output logic                    q_valid,
  output pmm_pkg::pmm_req_t       q_req
);
  import pmm_pkg::*;

  pmm_req_t         cls;
  logic [CNT_W-1:0] avail;
  pmm_req_t         slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;

  always_comb begin
    cls          = '0;
    cls.addr     = item.address;
    cls.wdata    = item.write_data;
    cls.frame    = item.frame_base[FRAME_W-1:0];
    cls.owner    = item.owner;
    cls.flags    = item.page_flags;
    cls.is_word  = (item.func == FN_RD_WORD) || (item.func == FN_WR_WORD);
    cls.is_write = (item.func == FN_WR_BYTE) || (item.func == FN_WR_WORD);
    // A run stops at the last page of the table.
    avail     = CNT_W'(CPU_PAGES) - {1'b0, item.address[15:8]};
    cls.pages = (item.page_count > avail) ? avail : item.page_count;
    case (item.func)
      FN_RD_BYTE, FN_RD_WORD, FN_WR_BYTE, FN_WR_WORD: begin
        if (item.address[15:8] == IO_PAGE) begin
          cls.kind = K_IO;
        end else begin
          cls.kind = K_MEM;
          if (cls.is_word) begin
            cls.addr = {item.address[15:1], 1'b0};
          end
        end
      end
      FN_MAP:   cls.kind = K_MAP;
      FN_UNMAP: cls.kind = K_UNMAP;
      default:  cls.kind = K_NONE;
    endcase
  end

  assign busy    = (count == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (count != 2'd0);
  assign q_req   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

FILE: design/pmm_back.sv
// Back end: page table, access translation and the map and unmap sequencer.
`default_nettype none
module pmm_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  input  wire pmm_pkg::pmm_req_t q_req,
  output logic                   pop,
  input  wire logic              cfg_valid,
  input  wire logic [7:0]        cfg_data,
  output logic                   done,
  output pmm_pkg::pmm_result_t   result
);
  import pmm_pkg::*;

  pmm_bk_state_t      state, state_next;
  pmm_entry_t         mem [CPU_PAGES];
  pmm_entry_t         rd_entry;
  logic [PAGE_W-1:0]  rd_addr;
  logic               mem_we;
  logic [CPU_PAGES-1:0] pt_vld;
  logic               set_vld;
  logic               clr_vld;
  logic [7:0]         wmask;

  logic               b_vld, b_vld_next;
  pmm_req_t           b_req;
  pmm_result_t        b_res;
  pmm_result_t        seq_res;
  logic               b_hit;

  logic [PAGE_W-1:0]  seq_page, seq_page_next;
  logic [CNT_W-1:0]   seq_left, seq_left_next;
  logic [FRAME_W-1:0] seq_frame, seq_frame_next;
  logic [7:0]         seq_owner, seq_owner_next;
  logic [7:0]         seq_flags, seq_flags_next;
  logic [CNT_W-1:0]   changed, changed_next;
  logic               chk_vld, chk_vld_next;
  logic [PAGE_W-1:0]  chk_page, chk_page_next;
  logic               match;
  logic               emit_seq;

  // An entry that has no valid bit reads as owner zero.
  assign match = pt_vld[chk_page] ? (rd_entry.owner == seq_owner) : (seq_owner == 8'd0);

  always_comb begin
    state_next     = state;
    pop            = 1'b0;
    b_vld_next     = 1'b0;
    rd_addr        = q_req.addr[15:8];
    mem_we         = 1'b0;
    set_vld        = 1'b0;
    clr_vld        = 1'b0;
    emit_seq       = 1'b0;
    seq_page_next  = seq_page;
    seq_left_next  = seq_left;
    seq_frame_next = seq_frame;
    seq_owner_next = seq_owner;
    seq_flags_next = seq_flags;
    changed_next   = changed;
    chk_vld_next   = 1'b0;
    chk_page_next  = chk_page;
    case (state)
      BK_RUN: begin
        if (q_valid) begin
          pop            = 1'b1;
          seq_page_next  = q_req.addr[15:8];
          seq_left_next  = q_req.pages;
          seq_frame_next = q_req.frame;
          seq_owner_next = q_req.owner;
          seq_flags_next = q_req.flags;
          changed_next   = '0;
          case (q_req.kind)
            K_MAP:   state_next = BK_MAP;
            K_UNMAP: state_next = BK_UNMAP;
            default: b_vld_next = 1'b1;
          endcase
        end
      end
      BK_MAP: begin
        if (seq_left != '0) begin
          mem_we         = 1'b1;
          set_vld        = 1'b1;
          seq_page_next  = seq_page + PAGE_W'(1);
          seq_left_next  = seq_left - CNT_W'(1);
          seq_frame_next = seq_frame + FRAME_W'(1);
          changed_next   = changed + CNT_W'(1);
        end else begin
          emit_seq   = 1'b1;
          state_next = BK_RUN;
        end
      end
      BK_UNMAP: begin
        // Owner is read into a register and compared in the next cycle, one page per cycle.
        rd_addr = seq_page;
        if (seq_left != '0) begin
          chk_vld_next  = 1'b1;
          chk_page_next = seq_page;
          seq_page_next = seq_page + PAGE_W'(1);
          seq_left_next = seq_left - CNT_W'(1);
        end
        if (chk_vld && match) begin
          clr_vld      = 1'b1;
          changed_next = changed + CNT_W'(1);
        end
        if ((seq_left == '0) && !chk_vld) begin
          emit_seq   = 1'b1;
          state_next = BK_RUN;
        end
      end
      default: state_next = BK_RUN;
    endcase
  end

  always_comb begin
    b_res = '0;
    b_hit = pt_vld[b_req.addr[15:8]];
    case (b_req.kind)
      K_IO: begin
        b_res.target       = TGT_IO;
        b_res.io_port      = b_req.addr[7:0];
        b_res.write_enable = b_req.is_write;
        b_res.io_replicate = !b_req.is_write && b_req.is_word;
        if (b_req.is_write) begin
          b_res.store_data = {8'd0, b_req.wdata[7:0]};
        end
      end
      K_MEM: begin
        if (b_hit) begin
          b_res.target      = TGT_MEM;
          b_res.phys_addr   = {rd_entry.frame, b_req.addr[7:0]};
          b_res.word_access = b_req.is_word;
          if (b_req.is_write && ((rd_entry.flags & wmask) != 8'd0)) begin
            b_res.write_enable = 1'b1;
            b_res.store_data   = b_req.is_word ? b_req.wdata : {8'd0, b_req.wdata[7:0]};
          end
        end else begin
          b_res.target = TGT_NONE;
        end
      end
      default: b_res.target = TGT_NONE;
    endcase
  end

  always_comb begin
    seq_res               = '0;
    seq_res.target        = TGT_MAP;
    seq_res.pages_changed = changed;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[seq_page] <= '{frame: seq_frame, owner: seq_owner, flags: seq_flags};
    end
    rd_entry <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pt_vld <= '0;
    end else if (set_vld) begin
      pt_vld[seq_page] <= 1'b1;
    end else if (clr_vld) begin
      pt_vld[chk_page] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wmask <= 8'd1;
    end else if (cfg_valid) begin
      wmask <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= BK_RUN;
      b_vld   <= 1'b0;
      chk_vld <= 1'b0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      b_vld   <= b_vld_next;
      chk_vld <= chk_vld_next;
      done    <= b_vld || emit_seq;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b_req <= q_req;
    end
    seq_page  <= seq_page_next;
    seq_left  <= seq_left_next;
    seq_frame <= seq_frame_next;
    seq_owner <= seq_owner_next;
    seq_flags <= seq_flags_next;
    changed   <= changed_next;
    chk_page  <= chk_page_next;
    result    <= emit_seq ? seq_res : b_res;
  end

`ifndef SYNTHESIS
  a_chk_only_unmap: assert property (@(posedge clk) disable iff (rst)
    chk_vld |-> (state == BK_UNMAP))
    else $error("owner compare pending outside an unmap run");

  a_no_access_during_seq: assert property (@(posedge clk) disable iff (rst)
    (state != BK_RUN) |-> !b_vld)
    else $error("access result pending while the sequencer owns the table");

  a_map_sets_valid: assert property (@(posedge clk) disable iff (rst)
    ((state == BK_MAP) && (seq_left != '0)) |=> pt_vld[$past(seq_page)])
    else $error("mapped page did not become valid");

  a_one_source: assert property (@(posedge clk) disable iff (rst)
    !(b_vld && emit_seq))
    else $error("access and map results collide on the output");
`endif

endmodule
`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for the paged memory map core with its fixed I/O page.
`default_nettype none
module tb;
  import pmm_pkg::*;

  // Function codes the block ignores.
  localparam logic [2:0] FN_RSVD_LO = 3'd6;
  localparam logic [2:0] FN_RSVD_HI = 3'd7;
  localparam int unsigned RAND_PHASES = 10;
  localparam int unsigned PHASE_ITEMS = 155;

  typedef struct {
    pmm_item_t   req;
    bit          typed;
    pmm_result_t want;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  pmm_item_t   item;
  logic        done;
  pmm_result_t result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;

  // Our own copy of the page table and the writable mask.
  logic             tbl_valid [CPU_PAGES];
  logic [9:0]       tbl_frame [CPU_PAGES];
  logic [7:0]       tbl_owner [CPU_PAGES];
  logic [7:0]       tbl_flags [CPU_PAGES];
  logic [7:0]       wr_mask;

  pmm_result_t xlat_queue[$];
  dir_row_t    dir_rows[$];
  int          errors;
  int          idle_gap;
  bit          burst;

  paged_memory_map_with_io_page_core dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic pmm_result_t translate_request(pmm_item_t r);
    pmm_result_t o;
    logic [15:0] a;
    logic [7:0]  pg;
    logic        is_word;
    logic        is_write;
    int          p;
    int          i;
    o = '0;
    o.target = TGT_NONE;
    is_word = (r.func == FN_RD_WORD) || (r.func == FN_WR_WORD);
    is_write = (r.func == FN_WR_BYTE) || (r.func == FN_WR_WORD);
    case (r.func)
      FN_RD_BYTE, FN_RD_WORD, FN_WR_BYTE, FN_WR_WORD: begin
        if (r.address[15:8] == IO_PAGE) begin
          // The I/O page is never aligned and never looked up.
          o.target = TGT_IO;
          o.io_port = r.address[7:0];
          if (is_write) begin
            o.write_enable = 1'b1;
            o.store_data = {8'h00, r.write_data[7:0]};
          end else if (is_word) begin
            o.io_replicate = 1'b1;
          end
        end else begin
          a = is_word ? (r.address & 16'hFFFE) : r.address;
          pg = a[15:8];
          if (tbl_valid[pg]) begin
            o.target = TGT_MEM;
            o.phys_addr = {tbl_frame[pg], a[7:0]};
            o.word_access = is_word;
            if (is_write && ((tbl_flags[pg] & wr_mask) != 8'h00)) begin
              o.write_enable = 1'b1;
              o.store_data = is_word ? r.write_data : {8'h00, r.write_data[7:0]};
            end
          end
        end
      end
      FN_MAP, FN_UNMAP: begin
        o.target = TGT_MAP;
        for (i = 0; i < int'(r.page_count); i++) begin
          p = int'(r.address[15:8]) + i;
          if (p >= CPU_PAGES) break;
          if (r.func == FN_MAP) begin
            tbl_valid[p] = 1'b1;
            tbl_frame[p] = r.frame_base + 10'(i);
            tbl_owner[p] = r.owner;
            tbl_flags[p] = r.page_flags;
            o.pages_changed++;
          end else if (tbl_owner[p] == r.owner) begin
            // Unmap matches the owner field even on entries that are invalid.
            tbl_valid[p] = 1'b0;
            tbl_frame[p] = '0;
            tbl_owner[p] = '0;
            tbl_flags[p] = '0;
            o.pages_changed++;
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic pmm_item_t mk_req(logic [2:0] func, logic [15:0] address,
                                       logic [15:0] wdata, logic [9:0] frame,
                                       logic [7:0] owner, logic [7:0] flags,
                                       logic [8:0] count);
    pmm_item_t r;
    r.func = func;
    r.address = address;
    r.write_data = wdata;
    r.frame_base = frame;
    r.owner = owner;
    r.page_flags = flags;
    r.page_count = count;
    return r;
  endfunction

  function automatic pmm_result_t mk_res(logic [1:0] target, logic [17:0] phys,
                                         logic we, logic word, logic [7:0] port,
                                         logic repl, logic [15:0] sdata,
                                         logic [8:0] changed);
    pmm_result_t o;
    o.target = target;
    o.phys_addr = phys;
    o.write_enable = we;
    o.word_access = word;
    o.io_port = port;
    o.io_replicate = repl;
    o.store_data = sdata;
    o.pages_changed = changed;
    return o;
  endfunction

  function automatic logic [8:0] draw_count();
    int k;
    k = $urandom_range(0, 19);
    if (k < 13) return 9'($urandom_range(1, 8));
    if (k < 17) return 9'($urandom_range(0, 40));
    if (k < 19) return 9'($urandom_range(41, 255));
    return 9'd256;
  endfunction

  // Owners come mostly from a small pool so that unmap requests find matches.
  function automatic logic [7:0] draw_owner();
    int k;
    k = $urandom_range(0, 9);
    case (k)
      0, 1: return 8'h00;
      2, 3: return 8'h5A;
      4, 5: return 8'hA5;
      6, 7: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pmm_item_t rand_request();
    pmm_item_t r;
    int        sel;
    r = mk_req(3'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
               10'($urandom_range(0, 1023)), 8'($urandom), 8'($urandom),
               9'($urandom_range(0, 256)));
    sel = $urandom_range(0, 99);
    if (sel < 9) begin
      r.func = FN_MAP;
      r.owner = draw_owner();
      r.page_count = draw_count();
    end else if (sel < 14) begin
      r.func = FN_UNMAP;
      r.owner = draw_owner();
      r.page_count = draw_count();
    end else if (sel < 16) begin
      r.func = $urandom_range(0, 1) ? FN_RSVD_LO : FN_RSVD_HI;
    end else if (sel < 30) begin
      r.address[15:8] = IO_PAGE;
    end
    return r;
  endfunction

  function automatic int draw_gap();
    if (burst) return 0;
    return $urandom_range(0, 13);
  endfunction

  // Called at a falling edge; returns at a falling edge.
  task automatic send(pmm_item_t r, bit typed, pmm_result_t want, bit more);
    pmm_result_t predicted;
    if (idle_gap > 0) repeat (idle_gap) @(negedge clk);
    start <= 1'b1;
    item <= r;
    do @(posedge clk); while (busy);
    predicted = translate_request(r);
    xlat_queue.push_back(typed ? want : predicted);
    @(negedge clk);
    idle_gap = more ? draw_gap() : 1;
    // Start stays high when the next request follows without a gap.
    if (idle_gap != 0) start <= 1'b0;
  endtask

  task automatic set_mask(logic [7:0] value);
    while (xlat_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    wr_mask = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    pmm_result_t want;
    if (!rst && done !== 1'b0) begin
      if (xlat_queue.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        want = xlat_queue.pop_front();
        check_field("target", 32'(want.target), 32'(result.target));
        check_field("phys_addr", 32'(want.phys_addr), 32'(result.phys_addr));
        check_field("write_enable", 32'(want.write_enable), 32'(result.write_enable));
        check_field("word_access", 32'(want.word_access), 32'(result.word_access));
        check_field("io_port", 32'(want.io_port), 32'(result.io_port));
        check_field("io_replicate", 32'(want.io_replicate), 32'(result.io_replicate));
        check_field("store_data", 32'(want.store_data), 32'(result.store_data));
        check_field("pages_changed", 32'(want.pages_changed),
                    32'(result.pages_changed));
      end
    end
  end

  initial begin
    pmm_result_t none_res;
    int          ph;
    int          n;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    errors = 0;
    idle_gap = 1;
    burst = 1'b0;
    wr_mask = 8'h01;
    for (n = 0; n < CPU_PAGES; n++) begin
      tbl_valid[n] = 1'b0;
      tbl_frame[n] = '0;
      tbl_owner[n] = '0;
      tbl_flags[n] = '0;
    end
    none_res = mk_res(TGT_NONE, 0, 0, 0, 0, 0, 0, 0);

    // Unmapped pages, the I/O page, frame wrap, read-only pages, runs past the
    // last page, owner matching on cleared entries and ignored functions.
    dir_rows.push_back('{mk_req(FN_RD_BYTE, 16'h1234, 0, 0, 0, 0, 0), 1'b1, none_res});
    dir_rows.push_back('{mk_req(FN_WR_WORD, 16'h0000, 16'hFFFF, 0, 0, 0, 0), 1'b1, none_res});
    dir_rows.push_back('{mk_req(FN_RD_WORD, 16'hFFFF, 0, 0, 0, 0, 0), 1'b1,
                         mk_res(TGT_IO, 0, 0, 0, 8'hFF, 1, 0, 0)});
    dir_rows.push_back('{mk_req(FN_WR_WORD, 16'hFF00, 16'hABCD, 0, 0, 0, 0), 1'b1,
                         mk_res(TGT_IO, 0, 1, 0, 8'h00, 0, 16'h00CD, 0)});
    dir_rows.push_back('{mk_req(FN_WR_BYTE, 16'hFF01, 16'h1234, 0, 0, 0, 0), 1'b1,
                         mk_res(TGT_IO, 0, 1, 0, 8'h01, 0, 16'h0034, 0)});
    dir_rows.push_back('{mk_req(FN_RD_BYTE, 16'hFF80, 0, 0, 0, 0, 0), 1'b1,
                         mk_res(TGT_IO, 0, 0, 0, 8'h80, 0, 0, 0)});
    dir_rows.push_back('{mk_req(FN_MAP, 16'h0000, 0, 10'h3FF, 8'h11, 8'h01, 9'd4), 1'b1,
                         mk_res(TGT_MAP, 0, 0, 0, 0, 0, 0, 9'd4)});
    dir_rows.push_back('{mk_req(FN_RD_BYTE, 16'h0005, 0, 0, 0, 0, 0), 1'b1,
                         mk_res(TGT_MEM, 18'h3FF05, 0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_req(FN_RD_WORD, 16'h01FF, 0, 0, 0, 0, 0), 1'b0, none_res});
    dir_rows.push_back('{mk_req(FN_WR_WORD, 16'h0203, 16'hBEEF, 0, 0, 0, 0), 1'b0, none_res});
    dir_rows.push_back('{mk_req(FN_WR_BYTE, 16'h03FF, 16'hFFFF, 0, 0, 0, 0), 1'b0, none_res});
    dir_rows.push_back('{mk_req(FN_MAP, 16'h1000, 0, 10'd5, 8'h22, 8'hFE, 9'd2), 1'b0, none_res});
    dir_rows.push_back('{mk_req(FN_WR_BYTE, 16'h1010, 16'h5A5A, 0, 0, 0, 0), 1'b0, none_res});
    dir_rows.push_back('{mk_req(FN_MAP, 16'hF000, 0, 10'd0, 8'h33, 8'hFF, 9'd256), 1'b1,
                         mk_res(TGT_MAP, 0, 0, 0, 0, 0, 0, 9'd16)});
    dir_rows.push_back('{mk_req(FN_RD_WORD, 16'hFF10, 0, 0, 0, 0, 0), 1'b1,
                         mk_res(TGT_IO, 0, 0, 0, 8'h10, 1, 0, 0)});
    dir_rows.push_back('{mk_req(FN_RD_WORD, 16'hF0FF, 0, 0, 0, 0, 0), 1'b0, none_res});
    dir_rows.push_back('{mk_req(FN_UNMAP, 16'h0000, 0, 0, 8'h11, 0, 9'd256), 1'b0, none_res});
    dir_rows.push_back('{mk_req(FN_UNMAP, 16'h0000, 0, 0, 8'h00, 0, 9'd256), 1'b0, none_res});
    dir_rows.push_back('{mk_req(FN_MAP, 16'h4000, 0, 0, 0, 0, 9'd0), 1'b1,
                         mk_res(TGT_MAP, 0, 0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_req(FN_UNMAP, 16'h1000, 0, 0, 8'h22, 0, 9'd0), 1'b1,
                         mk_res(TGT_MAP, 0, 0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_req(FN_RSVD_LO, 16'hFFFF, 16'hFFFF, 10'h3FF, 8'hFF, 8'hFF,
                                9'd256), 1'b1, none_res});
    dir_rows.push_back('{mk_req(FN_RSVD_HI, 16'h2000, 16'h8001, 10'h200, 8'h80, 8'h80,
                                9'd1), 1'b1, none_res});
    dir_rows.push_back('{mk_req(FN_MAP, 16'h00AB, 0, 10'h3FF, 8'hFF, 8'hFF, 9'd256), 1'b1,
                         mk_res(TGT_MAP, 0, 0, 0, 0, 0, 0, 9'd256)});
    dir_rows.push_back('{mk_req(FN_WR_WORD, 16'hFEFF, 16'hFFFF, 0, 0, 0, 0), 1'b0, none_res});
    dir_rows.push_back('{mk_req(FN_UNMAP, 16'h8000, 0, 0, 8'hFF, 0, 9'd256), 1'b0, none_res});

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k]) begin
      send(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].want, k != dir_rows.size() - 1);
    end

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: set_mask(8'hFF);
        1: set_mask(8'h01);
        2: set_mask(8'h80);
        default: set_mask(8'($urandom_range(1, 255)));
      endcase
      burst = (ph % 3 == 2);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        send(rand_request(), 1'b0, none_res, n != PHASE_ITEMS - 1);
      end
    end

    while (xlat_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: sim.f
design/pmm_pkg.sv
design/pmm_front.sv
design/pmm_back.sv
design/paged_memory_map_with_io_page_core.sv
verif/tb.sv
